@@ rtl/core/rbst_pkg.sv @@
// Shared types and constants for the ray versus box slab test.
package rbst_pkg;

  localparam int NUM_AXES  = 3;
  localparam int NUM_PAIRS = 6;

  // Ordered axis pairs (i, j), i != j: check hi_i / den_i >= lo_j / den_j.
  localparam int PAIR_I [NUM_PAIRS] = '{0, 0, 1, 1, 2, 2};
  localparam int PAIR_J [NUM_PAIRS] = '{1, 2, 0, 2, 0, 1};

  // Load enables for the two register stages inside each product unit.
  typedef struct packed {
    logic s2;
    logic s3;
  } rbst_stg_en_t;

endpackage

@@ rtl/core/rbst_if.sv @@
// Request and result channel interfaces of the ray versus box slab test.
interface rbst_in_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic signed [COORD_BITS-1:0] origin_z;
  logic signed [COORD_BITS-1:0] dir_x;
  logic signed [COORD_BITS-1:0] dir_y;
  logic signed [COORD_BITS-1:0] dir_z;
  logic signed [COORD_BITS-1:0] box_min_x;
  logic signed [COORD_BITS-1:0] box_min_y;
  logic signed [COORD_BITS-1:0] box_min_z;
  logic signed [COORD_BITS-1:0] box_max_x;
  logic signed [COORD_BITS-1:0] box_max_y;
  logic signed [COORD_BITS-1:0] box_max_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  output ready);
endinterface

interface rbst_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

@@ rtl/core/ray_box_slab_test.sv @@
// Top level of the ray versus axis-aligned box slab test pipeline.
//
// Each request carries a ray (origin, direction) and two planes per axis; the
// result is hit = 1 when some t >= 0 lies in the closed slab of every axis.
// The answer is exact: slab bounds stay as fractions (signed numerator over a
// positive |dir| denominator) and are compared by cross multiplication, so no
// reciprocal is ever rounded. A zero direction component is handled as a flat
// axis: a hit there needs the origin between (or on) its two planes. Planes may
// come in either order. The test reduces to: every non-flat axis has hi >= 0,
// and for every ordered pair of non-flat axes i != j, hi_i*den_j >= lo_j*den_i.
// Throughput is one request per cycle while the result side does not stall.
// There are four register stages: the request lands in stage 1 at its
// accepting edge and then moves on through stages 2, 3 and 4 to the output.
// Stage 1 forms the slab numerators and denominators, stages 2 and 3 hold
// the partial products and the full cross products of the twelve
// multipliers, and stage 4 is the output register that holds the compare
// result. A stall on the result side backs up through a per-stage ready
// chain, so stages that hold bubbles keep filling.
module ray_box_slab_test import rbst_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  rbst_in_if.sink   in_if,
  rbst_out_if.source out_if
);

  localparam int NW = COORD_BITS + 2;
  localparam int DW = COORD_BITS;
  localparam int PW = NW + DW;

  // Gather request fields per axis
  logic signed [COORD_BITS-1:0] org [NUM_AXES];
  logic signed [COORD_BITS-1:0] dir [NUM_AXES];
  logic signed [COORD_BITS-1:0] pla [NUM_AXES];
  logic signed [COORD_BITS-1:0] plb [NUM_AXES];

  assign org[0] = in_if.origin_x;
  assign org[1] = in_if.origin_y;
  assign org[2] = in_if.origin_z;
  assign dir[0] = in_if.dir_x;
  assign dir[1] = in_if.dir_y;
  assign dir[2] = in_if.dir_z;
  assign pla[0] = in_if.box_min_x;
  assign pla[1] = in_if.box_min_y;
  assign pla[2] = in_if.box_min_z;
  assign plb[0] = in_if.box_max_x;
  assign plb[1] = in_if.box_max_y;
  assign plb[2] = in_if.box_max_z;

  // Pipeline handshake: a stage advances when it is empty or the next one advances
  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;
  rbst_stg_en_t mul_en;

  assign adv4   = !v4_r || out_if.ready;
  assign adv3   = !v3_r || adv4;
  assign adv2   = !v2_r || adv3;
  assign adv1   = !v1_r || adv2;
  assign mul_en = '{s2: adv2, s3: adv3};

  assign in_if.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_if.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // Stage 1: slab setup per axis
  logic                  nz_nxt   [NUM_AXES];
  logic                  fmiss    [NUM_AXES];
  logic signed [NW-1:0]  lo_nxt   [NUM_AXES];
  logic signed [NW-1:0]  hi_nxt   [NUM_AXES];
  logic        [DW-1:0]  den_nxt  [NUM_AXES];

  logic                  nz_r     [NUM_AXES];
  logic signed [NW-1:0]  lo_r     [NUM_AXES];
  logic signed [NW-1:0]  hi_r     [NUM_AXES];
  logic        [DW-1:0]  den_r    [NUM_AXES];
  logic                  ok1_nxt, ok1_r;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbst_slab #(.COORD_BITS(COORD_BITS)) u_slab (
      .org       (org[a]),
      .dir       (dir[a]),
      .pla       (pla[a]),
      .plb       (plb[a]),
      .nz        (nz_nxt[a]),
      .flat_miss (fmiss[a]),
      .lo        (lo_nxt[a]),
      .hi        (hi_nxt[a]),
      .den       (den_nxt[a])
    );
  end

  // Drop the request early if a flat axis misses or a slab ends behind t = 0
  always_comb begin
    ok1_nxt = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (fmiss[a] || (nz_nxt[a] && hi_nxt[a][NW-1])) ok1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      ok1_r <= ok1_nxt;
      for (int a = 0; a < NUM_AXES; a++) begin
        nz_r[a]  <= nz_nxt[a];
        lo_r[a]  <= lo_nxt[a];
        hi_r[a]  <= hi_nxt[a];
        den_r[a] <= den_nxt[a];
      end
    end
  end

  // Stages 2 and 3: cross products per ordered axis pair
  logic                 pe1 [NUM_PAIRS];
  logic [NUM_PAIRS-1:0] pe2_r, pe3_r;
  logic                 ok2_r, ok3_r;
  logic signed [PW-1:0] pa  [NUM_PAIRS];
  logic signed [PW-1:0] pb  [NUM_PAIRS];

  for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_pair
    assign pe1[k] = nz_r[PAIR_I[k]] && nz_r[PAIR_J[k]];

    // hi_i * den_j
    rbst_pmul #(.NW(NW), .DW(DW)) u_mul_a (
      .clk  (clk),
      .en   (mul_en),
      .num  (hi_r[PAIR_I[k]]),
      .den  (den_r[PAIR_J[k]]),
      .prod (pa[k])
    );

    // lo_j * den_i
    rbst_pmul #(.NW(NW), .DW(DW)) u_mul_b (
      .clk  (clk),
      .en   (mul_en),
      .num  (lo_r[PAIR_J[k]]),
      .den  (den_r[PAIR_I[k]]),
      .prod (pb[k])
    );
  end

  // Carry the side flags alongside the products
  always_ff @(posedge clk) begin
    if (adv2) begin
      ok2_r <= ok1_r;
      for (int k = 0; k < NUM_PAIRS; k++) pe2_r[k] <= pe1[k];
    end
    if (adv3) begin
      ok3_r <= ok2_r;
      pe3_r <= pe2_r;
    end
  end

  // Stage 4: compare and hold the result
  logic hit_nxt, hit_r;

  always_comb begin
    hit_nxt = ok3_r;
    for (int k = 0; k < NUM_PAIRS; k++) begin
      if (pe3_r[k] && (pa[k] < pb[k])) hit_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) hit_r <= hit_nxt;
  end

  assign out_if.valid = v4_r;
  assign out_if.hit   = hit_r;

endmodule

@@ rtl/core/rbst_slab.sv @@
// Per-axis slab setup: signed plane distances, positive denominator, flat-axis test.
module rbst_slab import rbst_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic signed [COORD_BITS-1:0] org,
  input  logic signed [COORD_BITS-1:0] dir,
  input  logic signed [COORD_BITS-1:0] pla,
  input  logic signed [COORD_BITS-1:0] plb,
  output logic                         nz,
  output logic                         flat_miss,
  output logic signed [COORD_BITS+1:0] lo,
  output logic signed [COORD_BITS+1:0] hi,
  output logic        [COORD_BITS-1:0] den
);

  localparam int NW = COORD_BITS + 2;

  logic signed [NW-1:0]         n1, n2, m1, m2;
  logic signed [COORD_BITS-1:0] pmin, pmax;
  logic                         neg;

  assign neg  = dir[COORD_BITS-1];
  assign nz   = (dir != '0);
  assign pmin = (pla < plb) ? pla : plb;
  assign pmax = (pla < plb) ? plb : pla;
  // Flat axis: origin must sit inside the closed slab
  assign flat_miss = !nz && ((org < pmin) || (org > pmax));

  assign n1  = NW'(pla) - NW'(org);
  assign n2  = NW'(plb) - NW'(org);
  // Flip signs so the denominator is positive
  assign m1  = neg ? -n1 : n1;
  assign m2  = neg ? -n2 : n2;
  assign den = neg ? COORD_BITS'(-dir) : COORD_BITS'(dir);
  assign lo  = (m1 < m2) ? m1 : m2;
  assign hi  = (m1 < m2) ? m2 : m1;

endmodule

@@ rtl/core/rbst_pmul.sv @@
// Two-stage signed by unsigned multiplier built from four half-width partial products.
module rbst_pmul import rbst_pkg::*; #(
  parameter int NW = 34,
  parameter int DW = 32
) (
  input  logic                    clk,
  input  rbst_stg_en_t            en,
  input  logic signed [NW-1:0]    num,
  input  logic        [DW-1:0]    den,
  output logic signed [NW+DW-1:0] prod
);

  localparam int LW  = DW / 2;
  localparam int NHW = NW - LW;
  localparam int DHW = DW - LW;
  localparam int PW  = NW + DW;

  logic        [LW-1:0]      nl, dl;
  logic signed [NHW-1:0]     nh;
  logic        [DHW-1:0]     dh;

  logic        [2*LW-1:0]    pll_nxt, pll_r;
  logic        [LW+DHW-1:0]  plh_nxt, plh_r;
  logic signed [NHW+LW:0]    phl_nxt, phl_r;
  logic signed [NHW+DHW:0]   phh_nxt, phh_r;
  logic signed [PW-1:0]      prod_nxt, prod_r;

  assign nl = num[LW-1:0];
  assign nh = num[NW-1:LW];
  assign dl = den[LW-1:0];
  assign dh = den[DW-1:LW];

  assign pll_nxt = nl * dl;
  assign plh_nxt = nl * dh;
  assign phl_nxt = nh * $signed({1'b0, dl});
  assign phh_nxt = nh * $signed({1'b0, dh});

  always_ff @(posedge clk) begin
    if (en.s2) begin
      pll_r <= pll_nxt;
      plh_r <= plh_nxt;
      phl_r <= phl_nxt;
      phh_r <= phh_nxt;
    end
  end

  assign prod_nxt = PW'($signed({1'b0, pll_r}))
                  + (PW'($signed({1'b0, plh_r})) <<< LW)
                  + (PW'(phl_r) <<< LW)
                  + (PW'(phh_r) <<< (2 * LW));

  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

@@ rtl/core/rbst_chk.sv @@
// Port-level checker for the ray versus box slab test, bound to the top level.
module rbst_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  logic [2:0] cnt_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track requests in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("more requests in flight than pipeline stages");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("result without a pending request");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output is empty");

endmodule

bind ray_box_slab_test rbst_chk u_rbst_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready)
);

@@ tb/sv/ray_box_slab_test_pkg_tb.sv @@
// Shared predictor of the ray versus box slab test.
package rbst_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] pa [3];
    logic signed [31:0] pb [3];
  } ray_box_t;

  // Sign of an/ad - cn/cd, denominators positive; 128-bit cross products.
  function automatic int frac_sign(longint an, longint ad, longint cn, longint cd);
    logic signed [127:0] l, r;
    l = 128'(signed'(an)) * 128'(signed'(cd));
    r = 128'(signed'(cn)) * 128'(signed'(ad));
    if (l > r) return 1;
    if (l < r) return -1;
    return 0;
  endfunction

  function automatic logic predict_hit(ray_box_t rb);
    longint tmin_n, tmin_d, tmax_n, tmax_d, o, d, p, q, lo_p, hi_p, n1, n2, dn;
    bit bounded, miss;
    tmin_n = 0; tmin_d = 1; tmax_n = 0; tmax_d = 1;
    bounded = 0; miss = 0;
    for (int a = 0; a < 3; a++) begin
      o = rb.org[a]; d = rb.dir[a]; p = rb.pa[a]; q = rb.pb[a];
      lo_p = (p < q) ? p : q;
      hi_p = (p < q) ? q : p;
      if (d == 0) begin
        if (o < lo_p || o > hi_p) miss = 1;
        continue;
      end
      n1 = p - o; n2 = q - o; dn = d;
      if (d < 0) begin
        n1 = -n1; n2 = -n2; dn = -d;
      end
      if (n1 > n2) begin
        p = n1; n1 = n2; n2 = p;
      end
      if (frac_sign(n1, dn, tmin_n, tmin_d) > 0) begin
        tmin_n = n1; tmin_d = dn;
      end
      if (!bounded || frac_sign(n2, dn, tmax_n, tmax_d) < 0) begin
        tmax_n = n2; tmax_d = dn; bounded = 1;
      end
    end
    if (miss) return 1'b0;
    if (!bounded) return 1'b1;
    return frac_sign(tmax_n, tmax_d, tmin_n, tmin_d) >= 0;
  endfunction
endpackage

@@ tb/sv/ray_box_slab_test_test.sv @@
// Top level testbench of the ray versus box slab test.
module ray_box_slab_test_test;
  import rbst_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int HOLD_OFF = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rbst_in_if #(.COORD_BITS(32)) in_if();
  rbst_out_if out_if();

  ray_box_slab_test #(.COORD_BITS(32)) uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ray_box_t pending_rays [$];
  logic     expected_hits [$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_recv = 0;
  bit       stim_done = 0;
  bit       in_taken = 0;
  int       quiet_cycles = 0;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Append one request to the pending queue.
  task automatic queue_ray(ray_box_t rb);
    pending_rays = {pending_rays, rb};
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 64)) - 32;
      3: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // Bias toward small coordinates around a nearby box so both answers show up.
  function automatic ray_box_t rnd_ray();
    ray_box_t rb;
    int scale;
    scale = $urandom_range(0, 3) == 0 ? 0 : (1 << $urandom_range(2, 20));
    for (int a = 0; a < 3; a++) begin
      if (scale == 0) begin
        rb.org[a] = rnd_coord(); rb.dir[a] = rnd_coord();
        rb.pa[a] = rnd_coord(); rb.pb[a] = rnd_coord();
      end else begin
        rb.org[a] = $signed($urandom_range(0, 2 * scale)) - scale;
        rb.dir[a] = ($urandom_range(0, 7) == 0) ? 0 :
                    $signed($urandom_range(0, 2 * scale)) - scale;
        rb.pa[a] = $signed($urandom_range(0, 2 * scale)) - scale;
        rb.pb[a] = $signed($urandom_range(0, 2 * scale)) - scale;
      end
    end
    return rb;
  endfunction

  function automatic ray_box_t mk(int o, int d, int p, int q);
    ray_box_t rb;
    for (int a = 0; a < 3; a++) begin
      rb.org[a] = o; rb.dir[a] = d; rb.pa[a] = p; rb.pb[a] = q;
    end
    return rb;
  endfunction

  task automatic add_directed();
    ray_box_t rb;
    queue_ray(mk(0, 0, -1, 1));          // all flat, inside
    queue_ray(mk(5, 0, -1, 1));          // all flat, outside
    queue_ray(mk(1, 0, -1, 1));          // flat, on a plane
    queue_ray(mk(0, 1, 5, 3));           // planes reversed
    queue_ray(mk(0, 1, 4, 4));           // degenerate slab touched
    queue_ray(mk(0, 1, -5, -3));         // box behind origin
    queue_ray(mk(0, -1, -5, -3));        // negative direction
    queue_ray(mk(0, 1, 0, 0));           // touch at t = 0
    queue_ray(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    queue_ray(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000));
    queue_ray(mk(-1, -1, -1, -1));
    rb = mk(0, 1, 2, 4); rb.dir[1] = 2; rb.pa[1] = 9; rb.pb[1] = 10;
    queue_ray(rb);                       // disjoint slab ranges
    rb = mk(0, 3, 3, 6); rb.dir[2] = 0;
    queue_ray(rb);                       // one flat axis
    rb = mk(0, 0, -1, 1); rb.dir[0] = 1; rb.org[1] = 2;
    queue_ray(rb);                       // flat miss with moving axis
  endtask

  // Driver: present a request at the falling edge, hold until accepted.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (pending_rays.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
        in_if.valid     <= 1'b1;
        in_if.origin_x  <= pending_rays[0].org[0];
        in_if.origin_y  <= pending_rays[0].org[1];
        in_if.origin_z  <= pending_rays[0].org[2];
        in_if.dir_x     <= pending_rays[0].dir[0];
        in_if.dir_y     <= pending_rays[0].dir[1];
        in_if.dir_z     <= pending_rays[0].dir[2];
        in_if.box_min_x <= pending_rays[0].pa[0];
        in_if.box_min_y <= pending_rays[0].pa[1];
        in_if.box_min_z <= pending_rays[0].pa[2];
        in_if.box_max_x <= pending_rays[0].pb[0];
        in_if.box_max_y <= pending_rays[0].pb[1];
        in_if.box_max_z <= pending_rays[0].pb[2];
        pending_rays.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    // Receiver side: stall at random, or hold off entirely during pressure.
    out_if.ready <= !hold_recv && ($urandom_range(1, 100) > recv_stall_pct);
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    ray_box_t rb;
    logic want;
    in_taken = rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        rb.org = '{in_if.origin_x, in_if.origin_y, in_if.origin_z};
        rb.dir = '{in_if.dir_x, in_if.dir_y, in_if.dir_z};
        rb.pa  = '{in_if.box_min_x, in_if.box_min_y, in_if.box_min_z};
        rb.pb  = '{in_if.box_max_x, in_if.box_max_y, in_if.box_max_z};
        expected_hits = {expected_hits, predict_hit(rb)};
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_hits.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          want = expected_hits.pop_front();
          if (out_if.hit !== want)
            report($sformatf("hit got %b want %b", out_if.hit, want));
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog: drop the run when nothing moves for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("FAIL ray_box_slab_test");
      $finish;
    end
  end

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int k = 0; k < n; k++) queue_ray(rnd_ray());
    wait (pending_rays.size() == 0 && !in_if.valid && expected_hits.size() == 0);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.origin_x = '0; in_if.origin_y = '0; in_if.origin_z = '0;
    in_if.dir_x = '0; in_if.dir_y = '0; in_if.dir_z = '0;
    in_if.box_min_x = '0; in_if.box_min_y = '0; in_if.box_min_z = '0;
    in_if.box_max_x = '0; in_if.box_max_y = '0; in_if.box_max_z = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    add_directed();
    run_phase(300, 0, 0);
    // Hold off the receiver so the pipeline fills and the request side stalls.
    hold_recv = 1;
    for (int k = 0; k < 40; k++) queue_ray(rnd_ray());
    repeat (HOLD_OFF) @(posedge clk);
    hold_recv = 0;
    run_phase(0, 0, 0);
    run_phase(300, 66, 0);
    run_phase(300, 0, 66);
    run_phase(300, 33, 33);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("PASS ray_box_slab_test");
    end else begin
      $display("FAIL ray_box_slab_test");
    end
    $finish;
  end
endmodule
